/* rtl/core/bscst_pkg.sv */
// shared types and constants of the bhaskara sine, cosine and tangent core
package bscst_pkg;

   localparam int ACTION_W = 2;
   localparam int ANGLE_W  = 32;
   localparam int VALUE_W  = 45;
   localparam int ARG_W    = 45;
   localparam int MOD_W    = 44;
   localparam int RED_W    = 36;
   localparam int SIN_W    = 26;
   localparam int MAG_W    = 25;
   localparam int QUO_W    = 44;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [RED_W-1:0] PI_Q32         = 36'd13493037705;
   localparam logic [RED_W-1:0] TWO_PI_Q32     = 36'd26986075409;
   localparam logic [RED_W-1:0] HALF_PI_Q32    = 36'd6746518852;
   localparam logic [RED_W-1:0] FIVE_PI_SQ_Q30 = 36'd52987035159;
   localparam logic [13:0]      RECIP_TWO_PI   = 14'd10430;
   localparam logic [VALUE_W-1:0] OUT_LIMIT    = 45'd16777216000000;
   localparam logic [MAG_W-1:0] TAN_SMALL      = 25'd16;

   typedef enum logic [1:0] {
      OP_SIN  = 2'd0,
      OP_COS  = 2'd1,
      OP_TAN  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic signed [ARG_W-1:0]  arg_sin;
      logic signed [ARG_W-1:0]  arg_cos;
   } item_type;

endpackage

/* rtl/core/bhaskara_sine_cosine_tangent_core.sv */
// top level of the bhaskara sine, cosine and tangent core
// usage:
//   raise start with req_action (0 sine, 1 cosine, 2 tangent, 3 gives zero) and
//   req_angle (signed radians, 20 fraction bits); the request transfers at a
//   rising edge where start is high and busy is low
//   one result per request comes back on rsp_value (signed, 24 fraction bits,
//   saturated to +/-1e6), marked by rsp_strobe for exactly one cycle, in
//   request order
// path: from the request transfer to the strobed result a request passes
//   the front register, the queue, 34 stages of range reduction, product and
//   sine division, and 46 stages of tangent division and output register
// throughput: one request per cycle; every stage is pipelined, so busy stays
//   low in normal use and only rises if the queue were to fill
// reset: synchronous, active high; clears all valid flags, in-flight requests
//   are dropped and no strobe follows
// the receiver cannot stall: each result is taken in its strobe cycle
module bhaskara_sine_cosine_tangent_core #(
   parameter int QUEUE_DEPTH = bscst_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [bscst_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [bscst_pkg::ANGLE_W-1:0] req_angle,
   output logic                                 rsp_strobe,
   output logic signed [bscst_pkg::VALUE_W-1:0] rsp_value
);
   import bscst_pkg::*;

   logic     queue_full;
   logic     push_valid, pop_valid;
   item_type push_item, pop_item;
   logic     sine_valid;
   op_type   sine_op;
   logic signed [SIN_W-1:0] sine_s, sine_c;

   bscst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_angle  (req_angle),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   bscst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   bscst_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_item   (pop_item),
      .out_valid (sine_valid),
      .out_op    (sine_op),
      .out_sin   (sine_s),
      .out_cos   (sine_c)
   );

   bscst_tan u_tan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sine_valid),
      .in_op     (sine_op),
      .in_sin    (sine_s),
      .in_cos    (sine_c),
      .out_valid (rsp_strobe),
      .out_value (rsp_value)
   );

endmodule

/* rtl/core/bscst_front.sv */
// front end: takes requests, decodes the operation and widens the angles
module bscst_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bscst_pkg::ACTION_W-1:0]    req_action,
   input  logic signed [bscst_pkg::ANGLE_W-1:0] req_angle,
   input  logic                              queue_full,
   output logic                              push_valid,
   output bscst_pkg::item_type               push_item
);
   import bscst_pkg::*;

   logic     item_valid_ff, item_valid_in;
   item_type item_ff, item_in;
   logic     take;
   logic signed [ARG_W-1:0] x_sin;

   always_comb begin
      busy       = item_valid_ff && queue_full;
      take       = start && !busy;
      push_valid = item_valid_ff && !queue_full;
      push_item  = item_ff;

      if (take) begin
         item_valid_in = 1'b1;
      end else if (push_valid) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end

      x_sin = {req_angle[ANGLE_W-1], req_angle, 12'b0};
      item_in.arg_sin = x_sin;
      item_in.arg_cos = x_sin + $signed(ARG_W'(HALF_PI_Q32));
      case (req_action)
         OP_SIN:  item_in.op = OP_SIN;
         OP_COS:  item_in.op = OP_COS;
         OP_TAN:  item_in.op = OP_TAN;
         default: item_in.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/core/bscst_queue.sv */
// short queue between the front end and the arithmetic back end
module bscst_queue #(
   parameter int DEPTH = bscst_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  bscst_pkg::item_type  push_item,
   output logic                 full,
   output logic                 pop_valid,
   output bscst_pkg::item_type  pop_item
);
   import bscst_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_valid_ff;
   item_type         pop_item_ff;
   logic             push, pop;

   always_comb begin
      full  = (count_ff == CNT_W'(DEPTH));
      push  = push_valid && !full;
      pop   = (count_ff != '0);
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
      pop_valid = pop_valid_ff;
      pop_item  = pop_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pop_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_item;
      end
      pop_item_ff <= mem[head_ff];
   end

endmodule

/* rtl/core/bscst_sine.sv */
// sine lanes: range reduction, bhaskara product and a pipelined divider
module bscst_sine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  bscst_pkg::item_type                 in_item,
   output logic                                out_valid,
   output bscst_pkg::op_type                   out_op,
   output logic signed [bscst_pkg::SIN_W-1:0]  out_sin,
   output logic signed [bscst_pkg::SIN_W-1:0]  out_cos
);
   import bscst_pkg::*;

   localparam int PRE_STAGES = 9;
   localparam int LAT        = PRE_STAGES + MAG_W;
   localparam int DIV_W      = 61;

   logic   vld_ff [LAT];
   op_type op_ff  [LAT];
   logic signed [SIN_W-1:0] lane_out [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff[0] <= in_item.op;
      for (int k = 1; k < LAT; k++) begin
         op_ff[k] <= op_ff[k-1];
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_op    = op_ff[LAT-1];
   assign out_sin   = lane_out[0];
   assign out_cos   = lane_out[1];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [ARG_W-1:0] arg;
      logic [ARG_W-1:0] arg_abs;
      logic [41:0]      prod2;
      logic [ARG_W-1:0] sub3;
      logic [62:0]      prod8;
      logic [RED_W-1:0] b_full;

      logic [MOD_W-1:0] m1_ff, m1_in, m2_ff;
      logic [9:0]       qe2_ff, qe2_in;
      logic [RED_W-1:0] r3_ff, r3_in, r4_ff, r4_in, r5_ff, r5_in, r6_ff, r6_in;
      logic             neg_ff [PRE_STAGES-1];
      logic             neg5_in;
      logic [30:0]      a7_ff, a7_in;
      logic [31:0]      b7_ff, b7_in;
      logic [32:0]      p8_ff, p8_in;
      logic [RED_W-1:0] den9_in;
      logic [DIV_W-1:0] rem9_in;

      logic [DIV_W-1:0] rem_ff [MAG_W+1];
      logic [RED_W-1:0] den_ff [MAG_W+1];
      logic [MAG_W-1:0] q_ff   [MAG_W+1];
      logic             sgn_ff [MAG_W+1];
      logic [DIV_W-1:0] rem_in [MAG_W+1];
      logic [MAG_W-1:0] q_in   [MAG_W+1];

      assign arg = (l == 0) ? in_item.arg_sin : in_item.arg_cos;

      always_comb begin
         arg_abs = arg[ARG_W-1] ? ARG_W'(-arg) : ARG_W'(arg);
         m1_in   = arg_abs[MOD_W-1:0];
         // quotient estimate by reciprocal, low by at most one turn
         prod2   = 42'(m1_ff[MOD_W-1:16]) * 42'(RECIP_TWO_PI);
         qe2_in  = prod2[41:32];
         sub3    = ARG_W'(m2_ff) - ARG_W'(qe2_ff) * ARG_W'(TWO_PI_Q32);
         r3_in   = sub3[RED_W-1:0];
         r4_in   = (r3_ff >= TWO_PI_Q32) ? r3_ff - TWO_PI_Q32 : r3_ff;
         if (r4_ff > PI_Q32) begin
            r5_in   = TWO_PI_Q32 - r4_ff;
            neg5_in = !neg_ff[3];
         end else begin
            r5_in   = r4_ff;
            neg5_in = neg_ff[3];
         end
         r6_in   = (r5_ff > HALF_PI_Q32) ? PI_Q32 - r5_ff : r5_ff;
         b_full  = PI_Q32 - r6_ff;
         a7_in   = r6_ff[32:2];
         b7_in   = b_full[33:2];
         prod8   = 63'(a7_ff) * 63'(b7_ff);
         p8_in   = prod8[62:30];
         den9_in = FIVE_PI_SQ_Q30 - (RED_W'(p8_ff) << 2);
         rem9_in = (DIV_W'(p8_ff) << 28) + DIV_W'(den9_in >> 1);
      end

      always_ff @(posedge clock) begin
         m1_ff     <= m1_in;
         neg_ff[0] <= arg[ARG_W-1];
         m2_ff     <= m1_ff;
         qe2_ff    <= qe2_in;
         neg_ff[1] <= neg_ff[0];
         r3_ff     <= r3_in;
         neg_ff[2] <= neg_ff[1];
         r4_ff     <= r4_in;
         neg_ff[3] <= neg_ff[2];
         r5_ff     <= r5_in;
         neg_ff[4] <= neg5_in;
         r6_ff     <= r6_in;
         neg_ff[5] <= neg_ff[4];
         a7_ff     <= a7_in;
         b7_ff     <= b7_in;
         neg_ff[6] <= neg_ff[5];
         p8_ff     <= p8_in;
         neg_ff[7] <= neg_ff[6];
         rem_ff[0] <= rem9_in;
         den_ff[0] <= den9_in;
         q_ff[0]   <= '0;
         sgn_ff[0] <= neg_ff[7];
      end

      assign rem_in[0] = '0;
      assign q_in[0]   = '0;

      // one quotient bit per stage, most significant first
      for (genvar j = 1; j <= MAG_W; j++) begin : g_div
         localparam int B = MAG_W - j;
         always_comb begin
            rem_in[j] = rem_ff[j-1];
            q_in[j]   = q_ff[j-1];
            if ((rem_ff[j-1] >> B) >= DIV_W'(den_ff[j-1])) begin
               rem_in[j]  = rem_ff[j-1] - (DIV_W'(den_ff[j-1]) << B);
               q_in[j][B] = 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            rem_ff[j] <= rem_in[j];
            q_ff[j]   <= q_in[j];
            den_ff[j] <= den_ff[j-1];
            sgn_ff[j] <= sgn_ff[j-1];
         end
      end

      assign lane_out[l] = sgn_ff[MAG_W] ? -$signed({1'b0, q_ff[MAG_W]})
                                         :  $signed({1'b0, q_ff[MAG_W]});
   end

endmodule

/* rtl/core/bscst_tan.sv */
// result stage: tangent divider, special cases, saturation and output register
module bscst_tan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  bscst_pkg::op_type                    in_op,
   input  logic signed [bscst_pkg::SIN_W-1:0]   in_sin,
   input  logic signed [bscst_pkg::SIN_W-1:0]   in_cos,
   output logic                                 out_valid,
   output logic signed [bscst_pkg::VALUE_W-1:0] out_value
);
   import bscst_pkg::*;

   localparam int DIV_W = 49;

   logic [MAG_W-1:0] sm, cm;
   logic             small_cos;
   logic signed [VALUE_W-1:0] byp_in;

   logic             vld_ff [QUO_W+1];
   logic [DIV_W-1:0] rem_ff [QUO_W+1];
   logic [MAG_W-1:0] div_ff [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic             negq_ff [QUO_W+1];
   logic             useq_ff [QUO_W+1];
   logic signed [VALUE_W-1:0] byp_ff [QUO_W+1];
   logic [DIV_W-1:0] rem_in [QUO_W+1];
   logic [QUO_W-1:0] q_in   [QUO_W+1];

   logic [VALUE_W-1:0]        qc;
   logic signed [VALUE_W-1:0] value_in, value_ff;
   logic                      valid_ff;

   always_comb begin
      sm = in_sin[SIN_W-1] ? MAG_W'(-in_sin) : MAG_W'(in_sin);
      cm = in_cos[SIN_W-1] ? MAG_W'(-in_cos) : MAG_W'(in_cos);
      small_cos = (cm <= TAN_SMALL);
      case (in_op)
         OP_SIN:  byp_in = VALUE_W'(in_sin);
         OP_COS:  byp_in = VALUE_W'(in_cos);
         OP_TAN: begin
            // cosine too small: clamp to the positive limit for a positive sine, else to the negative limit
            if (in_sin > 0) begin
               byp_in = $signed(OUT_LIMIT);
            end else begin
               byp_in = -$signed(OUT_LIMIT);
            end
         end
         default: byp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) begin
            vld_ff[k] <= 1'b0;
         end
         valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= QUO_W; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         valid_ff <= vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= {sm, 24'b0} + DIV_W'(cm >> 1);
      div_ff[0]  <= cm;
      q_ff[0]    <= '0;
      negq_ff[0] <= (in_sin[SIN_W-1] != in_cos[SIN_W-1]);
      useq_ff[0] <= (in_op == OP_TAN) && !small_cos;
      byp_ff[0]  <= byp_in;
   end

   assign rem_in[0] = '0;
   assign q_in[0]   = '0;

   for (genvar j = 1; j <= QUO_W; j++) begin : g_div
      localparam int B = QUO_W - j;
      always_comb begin
         rem_in[j] = rem_ff[j-1];
         q_in[j]   = q_ff[j-1];
         if ((rem_ff[j-1] >> B) >= DIV_W'(div_ff[j-1])) begin
            rem_in[j]  = rem_ff[j-1] - (DIV_W'(div_ff[j-1]) << B);
            q_in[j][B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in[j];
         q_ff[j]    <= q_in[j];
         div_ff[j]  <= div_ff[j-1];
         negq_ff[j] <= negq_ff[j-1];
         useq_ff[j] <= useq_ff[j-1];
         byp_ff[j]  <= byp_ff[j-1];
      end
   end

   always_comb begin
      qc = (VALUE_W'(q_ff[QUO_W]) > OUT_LIMIT) ? OUT_LIMIT : VALUE_W'(q_ff[QUO_W]);
      if (useq_ff[QUO_W]) begin
         value_in = negq_ff[QUO_W] ? -$signed(qc) : $signed(qc);
      end else begin
         value_in = byp_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

/* test/testbench.sv */
// self-checking testbench of the bhaskara sine, cosine and tangent core
module testbench;
   import bscst_pkg::*;

   localparam longint PI_Q       = 64'd13493037705;
   localparam longint TWO_PI_Q   = 64'd26986075409;
   localparam longint HALF_PI_Q  = 64'd6746518852;
   localparam longint FIVE_PI_SQ = 64'd52987035159;
   localparam longint LIMIT      = 64'd16777216000000;
   localparam longint TINY_COS   = 64'd16;
   localparam int     LATENCY    = 82;

   typedef struct {
      op_type          op;
      logic [31:0]     angle;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ACTION_W-1:0] req_action = '0;
   logic signed [ANGLE_W-1:0] req_angle = '0;
   logic rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_value;

   request_type pending_reqs[$];
   logic [VALUE_W-1:0] expected_values[$];
   int error_count = 0;
   int gap_left = 0;
   bit took = 1'b0;
   bit hold_for_drain = 1'b0;

   bhaskara_sine_cosine_tangent_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_angle(req_angle),
      .rsp_strobe(rsp_strobe), .rsp_value(rsp_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint approx_sine(input longint x);
      bit neg;
      longint unsigned m, r, a, b, p, num, den;
      neg = x < 0;
      m = neg ? -x : x;
      r = m % TWO_PI_Q;
      if (r > PI_Q) begin
         r = TWO_PI_Q - r;
         neg = !neg;
      end
      if (r > HALF_PI_Q) r = PI_Q - r;
      a = r >> 2;
      b = (PI_Q - r) >> 2;
      p = (a * b) >> 30;
      num = 16 * p;
      den = FIVE_PI_SQ - 4 * p;
      m = ((num << 24) + den / 2) / den;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [VALUE_W-1:0] trig_value(input request_type rq);
      longint x, v, s, c, cm;
      longint unsigned sm, q;
      x = longint'(signed'(rq.angle)) * 4096;
      v = 0;
      case (rq.op)
         OP_SIN: v = approx_sine(x);
         OP_COS: v = approx_sine(x + HALF_PI_Q);
         OP_TAN: begin
            s = approx_sine(x);
            c = approx_sine(x + HALF_PI_Q);
            cm = c < 0 ? -c : c;
            if (cm <= TINY_COS) begin
               v = s > 0 ? LIMIT : -LIMIT;
            end else begin
               sm = s < 0 ? -s : s;
               q = ((sm << 24) + cm / 2) / cm;
               if (q > LIMIT) q = LIMIT;
               v = ((s < 0) != (c < 0)) ? -longint'(q) : longint'(q);
            end
         end
         default: v = 0;
      endcase
      if (v > LIMIT) v = LIMIT;
      if (v < -LIMIT) v = -LIMIT;
      return v[VALUE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic add_request(input op_type op, input logic [31:0] angle);
      request_type rq;
      rq.op = op;
      rq.angle = angle;
      pending_reqs.push_back(rq);
   endtask

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   // transfer seen at the rising edge: predict and retire the item
   always @(posedge clock) begin
      request_type rq;
      took <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         rq.op = op_type'(req_action);
         rq.angle = req_angle;
         expected_values.push_back(trig_value(rq));
         pending_reqs.pop_front();
      end
   end

   // driver: one transfer at most per cycle, inputs change on the falling edge
   always @(negedge clock) begin
      int gap;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !took) begin
         // hold the item until it transfers
      end else begin
         gap = took ? random_gap() : gap_left;
         if (hold_for_drain && expected_values.size() != 0) begin
            start <= 1'b0;
            gap_left <= gap;
         end else if (gap > 0) begin
            start <= 1'b0;
            gap_left <= gap - 1;
         end else if (pending_reqs.size() != 0) begin
            start <= 1'b1;
            req_action <= pending_reqs[0].op;
            req_angle <= pending_reqs[0].angle;
            gap_left <= 0;
         end else begin
            start <= 1'b0;
            gap_left <= 0;
         end
      end
   end

   // monitor: results arrive for one cycle, taken at the rising edge
   always @(posedge clock) begin
      logic [VALUE_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_value));
         end else begin
            want = expected_values.pop_front();
            if (rsp_value !== want)
               report_mismatch($sformatf("value %h, predicted %h", rsp_value, want));
         end
      end
   end

   initial begin
      logic [31:0] edges[$];
      op_type op;
      int pick;
      edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1,
                32'd1647099, 32'hffe6de05, 32'd3294199, 32'd4941298, 32'd6588397};
      foreach (edges[i]) begin
         add_request(OP_SIN, edges[i]);
         add_request(OP_COS, edges[i]);
         add_request(OP_TAN, edges[i]);
      end
      add_request(OP_NONE, 32'h12345678);
      add_request(OP_NONE, 32'h80000000);
      // random requests; tangents near odd pi/2 multiples, where cos vanishes
      for (int i = 0; i < 1020; i++) begin
         pick = $urandom_range(0, 99);
         op = op_type'($urandom_range(0, 2));
         if (pick < 5) op = OP_NONE;
         if (pick < 45)
            add_request(op, $urandom);
         else if (pick < 75)
            add_request(op, 32'(signed'($urandom_range(0, 14000000)) - 7000000));
         else
            add_request(OP_TAN, 32'(1647099 * (2 * int'($urandom_range(0, 40)) - 40
                                + 1) + int'($urandom_range(0, 64)) - 32));
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() >= 520) @(posedge clock);
      hold_for_drain = 1'b1;
      @(posedge clock);
      while (expected_values.size() != 0) @(posedge clock);
      hold_for_drain = 1'b0;
      while (pending_reqs.size() != 0) @(posedge clock);
      while (expected_values.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0)
         $display("bhaskara_sine_cosine_tangent_core regression: pass");
      else
         $display("bhaskara_sine_cosine_tangent_core regression: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("bhaskara_sine_cosine_tangent_core regression: fail");
      $finish;
   end

endmodule

/* bhaskara_sine_cosine_tangent_core.f */
rtl/core/bscst_pkg.sv
rtl/core/bscst_front.sv
rtl/core/bscst_queue.sv
rtl/core/bscst_sine.sv
rtl/core/bscst_tan.sv
rtl/core/bhaskara_sine_cosine_tangent_core.sv
test/testbench.sv
